// ===== rtl/core/pcsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsc_pkg
// Types, codes and constants shared by the packet class statistics counter.
// ----------------------------------------------------------------------------
package pcsc_pkg;

    // default counter width
    localparam int DEF_COUNTER_WIDTH = 32;

    // field widths
    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int PROTO_W   = 8;
    localparam int THR_W     = 16;
    localparam int VALUE_W   = 32;
    localparam int CID_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_THRESHOLD = 1'd1;

    // reset values of configuration registers
    localparam logic [ADDR_W-1:0] LOCAL_ADDR_RST     = 32'd0;
    localparam logic [THR_W-1:0]  WARN_THRESHOLD_RST = 16'd100;

    // item commands
    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_SNAP  = 1'b1;

    // ip protocol numbers
    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_IGMP = 8'd2;
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

    // service ports
    localparam logic [PORT_W-1:0] PORT_HTTP     = 16'd80;
    localparam logic [PORT_W-1:0] PORT_HTTPS    = 16'd443;
    localparam logic [PORT_W-1:0] PORT_DNS      = 16'd53;
    localparam logic [PORT_W-1:0] PORT_DHCP     = 16'd67;
    localparam logic [PORT_W-1:0] PORT_SSH      = 16'd22;
    localparam logic [PORT_W-1:0] PORT_FTP_DATA = 16'd20;
    localparam logic [PORT_W-1:0] PORT_FTP_CTRL = 16'd21;

    // class counter slots
    localparam int NUM_CLASS  = 12;
    localparam int CLS_SEL_W  = $clog2(NUM_CLASS);
    localparam int CLS_HTTP   = 0;
    localparam int CLS_HTTPS  = 1;
    localparam int CLS_DNS    = 2;
    localparam int CLS_DHCP   = 3;
    localparam int CLS_SSH    = 4;
    localparam int CLS_FTP    = 5;
    localparam int CLS_TCP    = 6;
    localparam int CLS_UDP    = 7;
    localparam int CLS_ICMP   = 8;
    localparam int CLS_IGMP   = 9;
    localparam int CLS_OTHERS = 10;
    localparam int CLS_TOTAL  = 11;

    // counter ids on readout
    localparam logic [CID_W-1:0] CID_INTERVAL = 4'd0;
    localparam logic [CID_W-1:0] CID_MAX      = 4'd1;
    localparam logic [CID_W-1:0] CID_HTTP     = 4'd2;
    localparam logic [CID_W-1:0] CID_LAST     = 4'd13;

    // input item
    typedef struct packed {
        logic               command;
        logic [PROTO_W-1:0] ip_protocol;
        logic [ADDR_W-1:0]  dest_addr;
        logic [PORT_W-1:0]  src_port;
        logic [PORT_W-1:0]  dst_port;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [CID_W-1:0]   counter_id;
        logic [VALUE_W-1:0] count_value;
        logic               over_threshold;
        logic               last;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic             count_pkt;
        logic             take_snap;
        logic             load_out;
        logic [CID_W-1:0] read_idx;
        logic             last;
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/core/pcsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsc_ctrl
// Controller: accepts items, sequences the fourteen counter reads of a
// snapshot and stalls the input channel while reads are pending.
// ----------------------------------------------------------------------------
module pcsc_ctrl
    import pcsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_command,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state           r_state;
    logic [CID_W-1:0] r_idx;
    logic             w_accept;

    // input handshake and commands
    always_comb begin
        o_in_stall      = (r_state != ST_IDLE);
        w_accept        = i_in_valid && !o_in_stall;
        o_cmd.count_pkt = w_accept && (i_command == CMD_COUNT);
        o_cmd.take_snap = w_accept && (i_command == CMD_SNAP);
        o_cmd.load_out  = (r_state == ST_READ) && i_status.out_free;
        o_cmd.read_idx  = r_idx;
        o_cmd.last      = (r_idx == CID_LAST);
    end

    // state and readout index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= CID_INTERVAL;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.take_snap) begin
                        r_state <= ST_READ;
                        r_idx   <= CID_INTERVAL;
                    end
                end
                ST_READ: begin
                    if (o_cmd.load_out) begin
                        if (o_cmd.last) begin
                            r_state <= ST_IDLE;
                            r_idx   <= CID_INTERVAL;
                        end else begin
                            r_idx <= r_idx + CID_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_idx   <= CID_INTERVAL;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/pcsc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsc_dp
// Datapath: configuration registers, packet classification, class and
// interval counters, snapshot registers and the output register.
// ----------------------------------------------------------------------------
module pcsc_dp
    import pcsc_pkg::*;
#(
    parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_item             i_in_item,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_item
);

    localparam int CMP_W = (COUNTER_WIDTH > THR_W) ? COUNTER_WIDTH : THR_W;
    localparam int VAL_W = (COUNTER_WIDTH > VALUE_W) ? COUNTER_WIDTH : VALUE_W;

    logic [ADDR_W-1:0]        r_local_addr;
    logic [THR_W-1:0]         r_warn;
    logic [COUNTER_WIDTH-1:0] r_interval;
    logic [COUNTER_WIDTH-1:0] r_max;
    logic [COUNTER_WIDTH-1:0] r_snap;
    logic                     r_over;
    logic [COUNTER_WIDTH-1:0] r_cls [NUM_CLASS];
    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic [PORT_W-1:0]        w_port;
    logic [NUM_CLASS-1:0]     w_inc;
    logic [CLS_SEL_W-1:0]     w_cls_sel;
    logic [COUNTER_WIDTH-1:0] w_read_val;
    logic [VAL_W-1:0]         w_val_ext;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= LOCAL_ADDR_RST;
            r_warn       <= WARN_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOCAL_ADDR:     r_local_addr <= i_cfg_data[ADDR_W-1:0];
                CFG_WARN_THRESHOLD: r_warn       <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // service port pick and class decode
    always_comb begin
        w_port = (i_in_item.dest_addr == r_local_addr) ? i_in_item.dst_port
                                                       : i_in_item.src_port;
        w_inc            = '0;
        w_inc[CLS_TOTAL] = 1'b1;
        unique case (i_in_item.ip_protocol)
            PROTO_ICMP: w_inc[CLS_ICMP] = 1'b1;
            PROTO_IGMP: w_inc[CLS_IGMP] = 1'b1;
            PROTO_TCP: begin
                w_inc[CLS_TCP] = 1'b1;
                unique case (w_port)
                    PORT_HTTP:     w_inc[CLS_HTTP]  = 1'b1;
                    PORT_HTTPS:    w_inc[CLS_HTTPS] = 1'b1;
                    PORT_DNS:      w_inc[CLS_DNS]   = 1'b1;
                    PORT_DHCP:     w_inc[CLS_DHCP]  = 1'b1;
                    PORT_SSH:      w_inc[CLS_SSH]   = 1'b1;
                    PORT_FTP_DATA: w_inc[CLS_FTP]   = 1'b1;
                    PORT_FTP_CTRL: w_inc[CLS_FTP]   = 1'b1;
                    default: ;
                endcase
            end
            PROTO_UDP: begin
                w_inc[CLS_UDP] = 1'b1;
                if (w_port == PORT_DNS) begin
                    w_inc[CLS_DNS] = 1'b1;
                end
            end
            default: w_inc[CLS_OTHERS] = 1'b1;
        endcase
    end

    // counters and snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= '0;
            r_max      <= '0;
            r_snap     <= '0;
            r_over     <= 1'b0;
            for (int i = 0; i < NUM_CLASS; i++) begin
                r_cls[i] <= '0;
            end
        end else if (i_cmd.count_pkt) begin
            r_interval <= r_interval + COUNTER_WIDTH'(1);
            for (int i = 0; i < NUM_CLASS; i++) begin
                if (w_inc[i]) begin
                    r_cls[i] <= r_cls[i] + COUNTER_WIDTH'(1);
                end
            end
        end else if (i_cmd.take_snap) begin
            r_snap     <= r_interval;
            r_interval <= '0;
            r_over     <= CMP_W'(r_interval) > CMP_W'(r_warn);
            if (r_max < r_interval) begin
                r_max <= r_interval;
            end
        end
    end

    // readout select
    always_comb begin
        w_cls_sel = CLS_SEL_W'(i_cmd.read_idx - CID_HTTP);
        priority if (i_cmd.read_idx == CID_INTERVAL) begin
            w_read_val = r_snap;
        end else if (i_cmd.read_idx == CID_MAX) begin
            w_read_val = r_max;
        end else if (w_cls_sel < CLS_SEL_W'(NUM_CLASS)) begin
            w_read_val = r_cls[w_cls_sel];
        end else begin
            w_read_val = '0;
        end
        w_val_ext = VAL_W'(w_read_val);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item.counter_id     <= i_cmd.read_idx;
            r_out_item.count_value    <= w_val_ext[VALUE_W-1:0];
            r_out_item.over_threshold <= r_over;
            r_out_item.last           <= i_cmd.last;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

endmodule

// ===== rtl/core/packet_class_statistics_counter_top.sv =====
`timescale 1ns / 1ps
// Packet items are counted at the edge they are accepted, no result, one per cycle
// while the input is not stalled. A snapshot item moves the controller into its read
// state, which loads one counter read per cycle into the output register while the
// output is not stalled: fourteen reads in all. The input stalls from the snapshot
// until the last read is loaded into the output register.
// Reset clears all counters, local_addr to 0 and warn_threshold to 100.
// ----------------------------------------------------------------------------
// packet_class_statistics_counter_top
// Counts packets by protocol and service port and reads the counters out on
// a snapshot item.
// ----------------------------------------------------------------------------
module packet_class_statistics_counter_top
    import pcsc_pkg::*;
#(
    parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // controller
    pcsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_item.command),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath
    pcsc_dp #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef ASSERT_OFF
    // a snapshot item blocks the input on the next cycle
    a_snap_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_item.command == CMD_SNAP)) |=> o_in_stall)
        else $error("input not stalled after snapshot");

    // counter ids in range
    a_cid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.counter_id <= CID_LAST))
        else $error("counter id out of range");

    // reads follow each other in order within a run
    a_cid_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_item.last) |=>
        (o_out_valid && (o_out_item.counter_id == $past(o_out_item.counter_id) + 4'd1)))
        else $error("counter read sequence broken");

    // the warning flag holds through a run
    a_over_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_item.last) |=>
        $stable(o_out_item.over_threshold))
        else $error("warning flag changed within a snapshot");

    // last only on the final counter
    a_last_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last) |-> (o_out_item.counter_id == CID_LAST))
        else $error("last flag on wrong counter");
`endif

endmodule

// ===== bench/pcsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsc_checker
// Watches the packet and readout channels of the statistics counter. It keeps
// its own copy of the counters and configuration. Each counter read is
// compared with the oldest read still due.
// ----------------------------------------------------------------------------
module pcsc_checker
    import pcsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_item,
    output int                   o_pending,
    output int                   o_errors
);

    // mirrored configuration and counter state
    logic [ADDR_W-1:0]  local_addr;
    logic [THR_W-1:0]   warn_thr;
    logic [VALUE_W-1:0] interval_cnt;
    logic [VALUE_W-1:0] max_interval;
    logic [VALUE_W-1:0] class_cnt [NUM_CLASS];
    t_out_item          expected_reads [$];
    int                 error_cnt = 0;

    // one class counter up by one, wrapping
    task automatic bump(input int slot);
        class_cnt[slot] = class_cnt[slot] + 1'b1;
    endtask

    // count one packet into total, interval, protocol and service classes
    task automatic count_packet(input t_in_item it);
        logic [PORT_W-1:0] port;
        begin
            port = (it.dest_addr == local_addr) ? it.dst_port : it.src_port;
            bump(CLS_TOTAL);
            interval_cnt = interval_cnt + 1'b1;
            case (it.ip_protocol)
                PROTO_ICMP: bump(CLS_ICMP);
                PROTO_IGMP: bump(CLS_IGMP);
                PROTO_TCP: begin
                    bump(CLS_TCP);
                    case (port)
                        PORT_HTTP:                    bump(CLS_HTTP);
                        PORT_HTTPS:                   bump(CLS_HTTPS);
                        PORT_DNS:                     bump(CLS_DNS);
                        PORT_DHCP:                    bump(CLS_DHCP);
                        PORT_SSH:                     bump(CLS_SSH);
                        PORT_FTP_DATA, PORT_FTP_CTRL: bump(CLS_FTP);
                        default: ;
                    endcase
                end
                PROTO_UDP: begin
                    bump(CLS_UDP);
                    if (port == PORT_DNS) bump(CLS_DNS);
                end
                default: bump(CLS_OTHERS);
            endcase
        end
    endtask

    // raise the max, queue the fourteen reads, clear the interval
    task automatic take_snapshot();
        logic [VALUE_W-1:0] snap;
        logic               over;
        t_out_item          rd;
        begin
            snap = interval_cnt;
            if (max_interval < snap) max_interval = snap;
            over = (snap > VALUE_W'(warn_thr));
            for (int k = 0; k <= int'(CID_LAST); k++) begin
                rd.counter_id = CID_W'(k);
                if (k == CID_INTERVAL) begin
                    rd.count_value = snap;
                end else if (k == CID_MAX) begin
                    rd.count_value = max_interval;
                end else begin
                    rd.count_value = class_cnt[k - CID_HTTP];
                end
                rd.over_threshold = over;
                rd.last           = (k == CID_LAST);
                expected_reads.push_back(rd);
            end
            interval_cnt = '0;
        end
    endtask

    // compare one accepted read with the oldest one due
    task automatic check_read(input t_out_item got);
        t_out_item want;
        begin
            if (expected_reads.size() == 0) begin
                $error("counter_id: unexpected read, expected none, got %0d", got.counter_id);
                error_cnt++;
            end else begin
                want = expected_reads.pop_front();
                if (got.counter_id !== want.counter_id) begin
                    $error("counter_id: expected %0d, got %0d",
                           want.counter_id, got.counter_id);
                    error_cnt++;
                end
                if (got.count_value !== want.count_value) begin
                    $error("count_value: expected %0d, got %0d",
                           want.count_value, got.count_value);
                    error_cnt++;
                end
                if (got.over_threshold !== want.over_threshold) begin
                    $error("over_threshold: expected %0b, got %0b",
                           want.over_threshold, got.over_threshold);
                    error_cnt++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, got.last);
                    error_cnt++;
                end
            end
        end
    endtask

    // sample both channels and the register port at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            local_addr   = LOCAL_ADDR_RST;
            warn_thr     = WARN_THRESHOLD_RST;
            interval_cnt = '0;
            max_interval = '0;
            foreach (class_cnt[i]) class_cnt[i] = '0;
            expected_reads.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_read(i_out_item);
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LOCAL_ADDR) begin
                    local_addr = i_cfg_data[ADDR_W-1:0];
                end else if (i_cfg_idx == CFG_WARN_THRESHOLD) begin
                    warn_thr = i_cfg_data[THR_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.command == CMD_SNAP) begin
                    take_snapshot();
                end else begin
                    count_packet(i_in_item);
                end
            end
        end
        o_pending <= expected_reads.size();
        o_errors  <= error_cnt;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives packet and snapshot items into the statistics counter under several
// register settings and idle patterns. The checker beside the block compares
// every counter read.
// ----------------------------------------------------------------------------
module testbench;
    import pcsc_pkg::*;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_LOCAL_ADDR;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;

    int                   pending;
    int                   fail_count;
    int                   idle_pct  = 0;
    int                   stall_pct = 0;
    logic [ADDR_W-1:0]    local_now = LOCAL_ADDR_RST;

    packet_class_statistics_counter_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    pcsc_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_pending   (pending),
        .o_errors    (fail_count)
    );

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    // readout stall
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // hard limit on run time
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_in_item make_pkt(input logic [PROTO_W-1:0] proto,
                                          input logic [ADDR_W-1:0]  daddr,
                                          input logic [PORT_W-1:0]  sport,
                                          input logic [PORT_W-1:0]  dport);
        t_in_item it;
        begin
            it.command     = CMD_COUNT;
            it.ip_protocol = proto;
            it.dest_addr   = daddr;
            it.src_port    = sport;
            it.dst_port    = dport;
            return it;
        end
    endfunction

    // snapshot carries random junk in the packet fields
    function automatic t_in_item snap_item();
        t_in_item it;
        begin
            it             = make_pkt(PROTO_W'($urandom), $urandom, PORT_W'($urandom),
                                      PORT_W'($urandom));
            it.command     = CMD_SNAP;
            return it;
        end
    endfunction

    // mostly service ports, else any port
    function automatic logic [PORT_W-1:0] pick_port();
        logic [PORT_W-1:0] svc [7];
        begin
            svc = '{PORT_HTTP, PORT_HTTPS, PORT_DNS, PORT_DHCP, PORT_SSH,
                    PORT_FTP_DATA, PORT_FTP_CTRL};
            if ($urandom_range(9) < 6) return svc[$urandom_range(6)];
            return PORT_W'($urandom);
        end
    endfunction

    function automatic t_in_item rand_item();
        logic [PROTO_W-1:0] proto;
        logic [ADDR_W-1:0]  daddr;
        int                 sel;
        begin
            if ($urandom_range(99) < 8) return snap_item();
            sel = $urandom_range(99);
            if (sel < 40) begin
                proto = PROTO_TCP;
            end else if (sel < 65) begin
                proto = PROTO_UDP;
            end else if (sel < 73) begin
                proto = PROTO_ICMP;
            end else if (sel < 81) begin
                proto = PROTO_IGMP;
            end else begin
                proto = PROTO_W'($urandom);
            end
            daddr = ($urandom_range(1) == 0) ? local_now : ADDR_W'($urandom);
            return make_pkt(proto, daddr, pick_port(), pick_port());
        end
    endfunction

    // optional idle gap, then hold the item until accepted
    task automatic send_item(input t_in_item it);
        begin
            if ($urandom_range(99) < idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < idle_pct) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_item  <= it;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
    endtask

    // stop sending until every read due has come
    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0]     val);
        begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we   <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stimulus
    initial begin
        logic [ADDR_W-1:0] far;
        logic [THR_W-1:0]  thr;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, local address zero
        far = '1;
        send_item(make_pkt(PROTO_TCP, '0, 16'd1234, PORT_HTTP));
        send_item(make_pkt(PROTO_TCP, '0, 16'd1234, PORT_HTTPS));
        send_item(make_pkt(PROTO_TCP, '0, 16'd1234, PORT_DNS));
        send_item(make_pkt(PROTO_TCP, '0, 16'd1234, PORT_DHCP));
        send_item(make_pkt(PROTO_TCP, '0, 16'd1234, PORT_SSH));
        send_item(make_pkt(PROTO_TCP, '0, 16'd1234, PORT_FTP_DATA));
        send_item(make_pkt(PROTO_TCP, '0, 16'd1234, PORT_FTP_CTRL));
        send_item(make_pkt(PROTO_TCP, '0, 16'd1234, 16'd8080));
        // remote destination: source port decides
        send_item(make_pkt(PROTO_TCP, far, PORT_HTTPS, PORT_HTTP));
        send_item(make_pkt(PROTO_TCP, far, PORT_FTP_CTRL, 16'd0));
        send_item(make_pkt(PROTO_UDP, '0, 16'd0, PORT_DNS));
        send_item(make_pkt(PROTO_UDP, far, PORT_DNS, 16'd9));
        // udp only knows dns
        send_item(make_pkt(PROTO_UDP, '0, 16'd0, PORT_DHCP));
        send_item(make_pkt(PROTO_UDP, far, PORT_HTTP, PORT_DNS));
        send_item(make_pkt(PROTO_ICMP, 32'h0A000001, 16'd7, 16'd7));
        send_item(make_pkt(PROTO_IGMP, 32'hE0000001, 16'd0, 16'd0));
        send_item(make_pkt(8'd0, 32'h12345678, 16'd53, 16'd53));
        send_item(make_pkt(8'hFF, far, 16'hFFFF, 16'hFFFF));
        send_item(snap_item());
        // back to back snapshot sees an empty interval, max held
        send_item(snap_item());
        send_item(make_pkt(PROTO_TCP, '0, 16'd0, PORT_SSH));
        send_item(snap_item());

        // random phases, each under its own registers and idle pattern
        for (int p = 0; p < 7; p++) begin
            wait_drained();
            case (p)
                0:       begin local_now = '1;         thr = '0;    end
                1:       begin local_now = '0;         thr = '1;    end
                2:       begin local_now = $urandom;   thr = 16'd3; end
                3:       begin local_now = 32'hC0A80001; thr = 16'd20; end
                4:       begin local_now = $urandom;   thr = 16'd1; end
                5:       begin local_now = $urandom;   thr = 16'd8; end
                default: begin local_now = $urandom;   thr = THR_W'($urandom_range(15)); end
            endcase
            write_reg(CFG_LOCAL_ADDR, CFG_W'(local_now));
            write_reg(CFG_WARN_THRESHOLD, CFG_W'(thr));
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 84; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 7;  stall_pct = 7;  end
            endcase
            for (int n = 0; n < 29; n++) send_item(rand_item());
            send_item(snap_item());
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pcsc_pkg.sv
rtl/core/pcsc_ctrl.sv
rtl/core/pcsc_dp.sv
rtl/core/packet_class_statistics_counter_top.sv
bench/pcsc_checker.sv
bench/testbench.sv
